// ===== sv/rre_pkg.sv =====
// ---------------------------------------------------------------------------
// RTT/RTO estimator package
// Shared types, register indexes, reset values and the clamp function.
// ---------------------------------------------------------------------------
`default_nettype none

package rre_pkg;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned RTO_W   = 16;
	localparam int unsigned CNT_W   = 4;
	localparam int unsigned SRTT_W  = 20;
	localparam int unsigned DEV_W   = 19;
	localparam int unsigned SUM_W   = 20;

	localparam logic [1:0] REG_FLOOR   = 2'd0;
	localparam logic [1:0] REG_CEILING = 2'd1;
	localparam logic [1:0] REG_LIMIT   = 2'd2;

	localparam logic [1:0] REQ_NEW     = 2'd0;
	localparam logic [1:0] REQ_MEASURE = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT = 2'd2;

	localparam logic [RTO_W-1:0] FLOOR_RESET   = 16'd1000;
	localparam logic [RTO_W-1:0] CEILING_RESET = 16'd60000;
	localparam logic [CNT_W-1:0] LIMIT_RESET   = 4'd3;
	localparam logic [DEV_W-1:0] DEV_RESET     = 19'd3000;
	localparam logic [RTO_W-1:0] RTO_RESET     = 16'd3000;
	localparam logic [CNT_W-1:0] CNT_MAX       = 4'd15;

	typedef struct packed {
		logic [RTO_W-1:0] rto_floor;
		logic [RTO_W-1:0] rto_ceiling;
		logic [CNT_W-1:0] retransmit_limit;
	} rre_cfg_t;

	function automatic logic [RTO_W-1:0] clamp_rto(
		input logic [SUM_W-1:0] v,
		input logic [RTO_W-1:0] lo,
		input logic [RTO_W-1:0] hi
	);
		logic [RTO_W-1:0] r;
		if (v < {4'd0, lo}) begin
			r = lo;
		end else if (v > {4'd0, hi}) begin
			r = hi;
		end else begin
			r = v[RTO_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/rtt_rto_estimator.sv =====
// ---------------------------------------------------------------------------
// RTT/RTO estimator
// Retransmission timeout estimator with smoothed RTT and mean deviation.
// ---------------------------------------------------------------------------
// Each input beat carries a request type and, for measurements, a round
// trip time in milliseconds. Every input beat produces exactly one output
// beat with the timeout, the retransmit count and the give-up flag.
// An accepted beat is held in the input register, where the estimator state
// is updated, and its result is registered into the output register when
// the beat advances. One beat per cycle is sustained while out_ready stays
// high; the state update is a single pass of adds, shifts and compares per
// cycle. When the receiver stalls, the result stays in the output register
// and one more beat is taken into the input register before in_ready drops.
// Reset clears both registers and loads the default limits, a zero smoothed
// RTT, a deviation of 3000 and a timeout of 3000 ms. Configuration is to be
// written over the APB-style port while no beat is in flight; the block does
// not enforce it. New limits take effect at the next measurement or timeout.
// ---------------------------------------------------------------------------
`default_nettype none

module rtt_rto_estimator (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rre_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [rre_pkg::PDATA_W-1:0]  pwdata,
	output logic      [rre_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   req_type,
	input  wire logic [15:0]                  measured_ms,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [15:0]                  rto_ms,
	output logic      [3:0]                   retransmits,
	output logic                              give_up
);

	rre_pkg::rre_cfg_t cfg;

	logic        valid_s1;
	logic [1:0]  req_type_s1;
	logic [15:0] measured_s1;
	logic        advance;

	logic [rre_pkg::SRTT_W-1:0] srtt_q;
	logic [rre_pkg::DEV_W-1:0]  dev_q;
	logic [rre_pkg::RTO_W-1:0]  rto_q;
	logic [rre_pkg::CNT_W-1:0]  cnt_q;

	logic [rre_pkg::SRTT_W-1:0] srtt_d;
	logic [rre_pkg::DEV_W-1:0]  dev_d;
	logic [rre_pkg::RTO_W-1:0]  rto_d;
	logic [rre_pkg::CNT_W-1:0]  cnt_d;
	logic                       give_d;

	logic        out_valid_q;
	logic [15:0] rto_out_q;
	logic [3:0]  cnt_out_q;
	logic        give_out_q;

	logic [16:0]                mean;
	logic [16:0]                meas_ext;
	logic [16:0]                mag;
	logic [16:0]                quarter;
	logic                       meas_ge;
	logic [rre_pkg::SRTT_W-1:0] srtt_meas;
	logic [rre_pkg::DEV_W-1:0]  dev_meas;
	logic [rre_pkg::SUM_W-1:0]  rto_sum;
	logic [rre_pkg::SUM_W-1:0]  rto_dbl;
	logic [rre_pkg::CNT_W:0]    cnt_next;

	rre_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1 <= req_type;
			measured_s1 <= measured_ms;
		end
	end

	always_comb begin
		mean      = srtt_q[19:3];
		meas_ext  = {1'b0, measured_s1};
		meas_ge   = meas_ext >= mean;
		mag       = meas_ge ? (meas_ext - mean) : (mean - meas_ext);
		srtt_meas = meas_ge ? (srtt_q + {3'd0, mag}) : (srtt_q - {3'd0, mag});
		quarter   = dev_q[18:2];
		dev_meas  = dev_q + {2'd0, mag} - {2'd0, quarter};
		rto_sum   = {3'd0, srtt_meas[19:3]} + {1'b0, dev_meas};
		rto_dbl   = {3'd0, rto_q, 1'b0};
		cnt_next  = {1'b0, cnt_q} + 5'd1;

		srtt_d = srtt_q;
		dev_d  = dev_q;
		rto_d  = rto_q;
		cnt_d  = cnt_q;
		give_d = 1'b0;
		case (req_type_s1)
			rre_pkg::REQ_NEW: begin
				cnt_d = '0;
			end
			rre_pkg::REQ_MEASURE: begin
				srtt_d = srtt_meas;
				dev_d  = dev_meas;
				rto_d  = rre_pkg::clamp_rto(rto_sum, cfg.rto_floor, cfg.rto_ceiling);
			end
			rre_pkg::REQ_TIMEOUT: begin
				rto_d  = rre_pkg::clamp_rto(rto_dbl, cfg.rto_floor, cfg.rto_ceiling);
				give_d = cnt_next > {1'b0, cfg.retransmit_limit};
				cnt_d  = cnt_next[4] ? rre_pkg::CNT_MAX : cnt_next[3:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srtt_q <= '0;
			dev_q  <= rre_pkg::DEV_RESET;
			rto_q  <= rre_pkg::RTO_RESET;
			cnt_q  <= '0;
		end else if (advance) begin
			srtt_q <= srtt_d;
			dev_q  <= dev_d;
			rto_q  <= rto_d;
			cnt_q  <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rto_out_q  <= rto_d;
			cnt_out_q  <= cnt_d;
			give_out_q <= give_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign rto_ms      = rto_out_q;
	assign retransmits = cnt_out_q;
	assign give_up     = give_out_q;

endmodule

`default_nettype wire

// ===== sv/rre_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// RTT/RTO estimator configuration registers
// APB-style register file holding the timeout floor, ceiling and limit.
// ---------------------------------------------------------------------------
`default_nettype none

module rre_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rre_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [rre_pkg::PDATA_W-1:0]  pwdata,
	output logic      [rre_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	output rre_pkg::rre_cfg_t                 cfg
);

	rre_pkg::rre_cfg_t cfg_q;
	logic              wr_en;
	logic [1:0]        idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rto_floor        <= rre_pkg::FLOOR_RESET;
			cfg_q.rto_ceiling      <= rre_pkg::CEILING_RESET;
			cfg_q.retransmit_limit <= rre_pkg::LIMIT_RESET;
		end else if (wr_en) begin
			case (idx)
				rre_pkg::REG_FLOOR:   cfg_q.rto_floor        <= pwdata[15:0];
				rre_pkg::REG_CEILING: cfg_q.rto_ceiling      <= pwdata[15:0];
				rre_pkg::REG_LIMIT:   cfg_q.retransmit_limit <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rre_pkg::REG_FLOOR:   prdata = {16'd0, cfg_q.rto_floor};
			rre_pkg::REG_CEILING: prdata = {16'd0, cfg_q.rto_ceiling};
			rre_pkg::REG_LIMIT:   prdata = {28'd0, cfg_q.retransmit_limit};
			default:              prdata = '0;
		endcase
	end

endmodule

`default_nettype wire
